// ===== hdl/mlcd_pkg.sv =====
// Shared types and constants for the magic/length/checksum deframer.
`timescale 1ns / 1ps

package mlcd_pkg;

   localparam int MAX_PACKET_LEN_DEF = 512;

   localparam logic [31:0] MAGIC_WORD = 32'h544A_5347;
   localparam logic [7:0]  MAGIC_B2   = 8'h53;
   localparam logic [7:0]  MAGIC_B3   = 8'h47;
   localparam logic [7:0]  MAGIC_SUM  = 8'h38;
   localparam logic [15:0] MIN_LEN    = 16'd9;
   localparam logic [8:0]  DROP_OFFSET = 9'd5;
   localparam logic [2:0]  WINDOW_FULL = 3'd4;
   localparam logic [2:0]  WINDOW_NEAR = 3'd3;
   localparam int          BODY_START = 6;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_LEN_HI = 2'd1,
      PH_LEN_LO = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IN_PROGRESS = 2'd0,
      ST_GOOD_END    = 2'd1,
      ST_BAD_SUM     = 2'd2,
      ST_BAD_LEN     = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  pkt_byte;
      logic [8:0]  byte_offset;
      logic [15:0] pkt_len;
      logic        end_of_packet;
      status_type  status;
   } rsp_word_type;

endpackage

// ===== hdl/mlcd_word_if.sv =====
// Valid/ready word channel carrying one payload struct.
`timescale 1ns / 1ps

interface mlcd_word_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/magic_length_checksum_deframer_core.sv =====
// Deframer top level: magic hunt, length check, body pass-through and checksum.
//
// Accepts one received byte per clock and sustains that rate as long as rsp_ch is
// taken. A byte is held in an input register, then one pass of compare/add logic updates
// the frame state and loads the result register, which drives rsp_ch.
// Hunt and header bytes give no word; body bytes from offset 6 on
// give one word each, the checksum byte ending the packet with good or bad status; a
// header length under 9 or over MAX_PACKET_LEN gives a single drop word (status 3) and
// the hunt resumes from the second magic byte. Only the output register and the input
// register can stall, so backpressure on rsp_ch stops req_ch within one word.
`timescale 1ns / 1ps

module magic_length_checksum_deframer_core #(
   parameter int MAX_PACKET_LEN = mlcd_pkg::MAX_PACKET_LEN_DEF
) (
   input logic clock,
   input logic reset,
   mlcd_word_if.sink   req_ch,
   mlcd_word_if.source rsp_ch
);

   localparam int LEN_W = $clog2(MAX_PACKET_LEN + 1);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   // frame state
   mlcd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]      window_ff, window_in;
   logic [2:0]       fill_ff, fill_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic [LEN_W-1:0] exp_len_ff, exp_len_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;

   // result register
   logic                  rsp_valid_ff;
   mlcd_pkg::rsp_word_type rsp_data_ff, rsp_data_in;
   logic                  fire;

   logic [31:0] shifted;
   logic [15:0] total;
   logic        bad_len;
   logic        last;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign shifted = {window_ff[23:0], in_byte_ff};
   assign total   = {len_hi_ff, in_byte_ff};
   assign bad_len = (total < mlcd_pkg::MIN_LEN)
                 || ({1'b0, total} > 17'(MAX_PACKET_LEN));
   assign last    = ({1'b0, count_ff} + 1'b1) >= {1'b0, exp_len_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data.rx_byte;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         mlcd_pkg::PH_HUNT: begin
            if (fill_ff >= mlcd_pkg::WINDOW_NEAR && shifted == mlcd_pkg::MAGIC_WORD) begin
               phase_in = mlcd_pkg::PH_LEN_HI;
            end
         end
         mlcd_pkg::PH_LEN_HI: phase_in = mlcd_pkg::PH_LEN_LO;
         mlcd_pkg::PH_LEN_LO: phase_in = bad_len ? mlcd_pkg::PH_HUNT : mlcd_pkg::PH_BODY;
         mlcd_pkg::PH_BODY:   phase_in = last ? mlcd_pkg::PH_HUNT : mlcd_pkg::PH_BODY;
         default:             phase_in = mlcd_pkg::PH_HUNT;
      endcase
   end

   // datapath and result
   always_comb begin
      window_in   = window_ff;
      fill_in     = fill_ff;
      len_hi_in   = len_hi_ff;
      exp_len_in  = exp_len_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      fire        = 1'b0;
      rsp_data_in.pkt_byte      = in_byte_ff;
      rsp_data_in.byte_offset   = 9'(count_ff);
      rsp_data_in.pkt_len       = 16'(exp_len_ff);
      rsp_data_in.end_of_packet = 1'b0;
      rsp_data_in.status        = mlcd_pkg::ST_IN_PROGRESS;
      unique case (phase_ff)
         mlcd_pkg::PH_HUNT: begin
            window_in = shifted;
            if (fill_ff < mlcd_pkg::WINDOW_FULL) begin
               fill_in = fill_ff + 3'd1;
            end
         end
         mlcd_pkg::PH_LEN_HI: begin
            len_hi_in = in_byte_ff;
         end
         mlcd_pkg::PH_LEN_LO: begin
            if (bad_len) begin
               // drop: rescan from the second magic byte
               window_in = {mlcd_pkg::MAGIC_B2, mlcd_pkg::MAGIC_B3, total};
               fill_in   = mlcd_pkg::WINDOW_FULL;
               fire      = 1'b1;
               rsp_data_in.pkt_byte      = 8'd0;
               rsp_data_in.byte_offset   = mlcd_pkg::DROP_OFFSET;
               rsp_data_in.pkt_len       = total;
               rsp_data_in.end_of_packet = 1'b1;
               rsp_data_in.status        = mlcd_pkg::ST_BAD_LEN;
            end else begin
               exp_len_in = LEN_W'(total);
               count_in   = LEN_W'(mlcd_pkg::BODY_START);
               sum_in     = mlcd_pkg::MAGIC_SUM + len_hi_ff + in_byte_ff;
            end
         end
         mlcd_pkg::PH_BODY: begin
            fire = 1'b1;
            if (last) begin
               window_in = '0;
               fill_in   = '0;
               rsp_data_in.end_of_packet = 1'b1;
               rsp_data_in.status = (in_byte_ff == sum_ff) ? mlcd_pkg::ST_GOOD_END
                                                          : mlcd_pkg::ST_BAD_SUM;
            end else begin
               sum_in   = sum_ff + in_byte_ff;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            fire = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mlcd_pkg::PH_HUNT;
         window_ff  <= '0;
         fill_ff    <= '0;
         len_hi_ff  <= '0;
         exp_len_ff <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         len_hi_ff  <= len_hi_in;
         exp_len_ff <= exp_len_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hdl/mlcd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps

module mlcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_pkt_byte,
   input logic [8:0]  rsp_byte_offset,
   input logic [15:0] rsp_pkt_len,
   input logic        rsp_end_of_packet,
   input logic [1:0]  rsp_status
);

   // stalled word holds its byte, offset and status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pkt_byte)
         && $stable(rsp_byte_offset) && $stable(rsp_status))
      else $error("rsp word changed while stalled");

   // end flag agrees with status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_packet == (rsp_status != mlcd_pkg::ST_IN_PROGRESS)))
      else $error("end_of_packet disagrees with status");

   // drop word shape
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mlcd_pkg::ST_BAD_LEN |->
         rsp_pkt_byte == 8'd0 && rsp_byte_offset == mlcd_pkg::DROP_OFFSET)
      else $error("malformed length-drop word");

   // packet words carry a length of at least the minimum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mlcd_pkg::ST_BAD_LEN |-> rsp_pkt_len >= mlcd_pkg::MIN_LEN)
      else $error("packet word with short length");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind magic_length_checksum_deframer_core mlcd_checker u_mlcd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_pkt_byte      (rsp_ch.data.pkt_byte),
   .rsp_byte_offset   (rsp_ch.data.byte_offset),
   .rsp_pkt_len       (rsp_ch.data.pkt_len),
   .rsp_end_of_packet (rsp_ch.data.end_of_packet),
   .rsp_status        (rsp_ch.data.status)
);

// ===== sim/tb_magic_length_checksum_deframer_core.sv =====
// Testbench for the magic/length/checksum deframer: directed and random byte streams.
`timescale 1ns / 1ps

module tb_magic_length_checksum_deframer_core;

   localparam int          FRAME_MAX_LEN = 512;
   localparam int          FRAME_MIN_LEN = 9;
   localparam logic [31:0] HDR_MAGIC     = 32'h544A_5347;
   localparam logic [7:0]  HDR_MAGIC_SUM = 8'h38;
   localparam logic [8:0]  DROP_AT       = 9'd5;
   localparam int          ITEM_GOAL     = 1900;
   localparam int          CYCLE_LIMIT   = 600000;

   logic clock;
   logic reset;

   mlcd_word_if #(.payload_type(mlcd_pkg::req_word_type)) req_ch ();
   mlcd_word_if #(.payload_type(mlcd_pkg::rsp_word_type)) rsp_ch ();

   magic_length_checksum_deframer_core #(.MAX_PACKET_LEN(FRAME_MAX_LEN)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // frame tracker state
   logic [31:0]          hunt_window;
   logic [2:0]           hunt_fill;
   mlcd_pkg::phase_type  frame_phase;
   logic [7:0]           len_high;
   logic [15:0]          frame_len;
   logic [9:0]           byte_count;
   logic [7:0]           frame_sum;

   mlcd_pkg::rsp_word_type pending_pkt_words[$];
   int           mismatch_count = 0;
   int           words_seen = 0;
   int           bytes_sent = 0;
   int           burst_left = 0;
   int           stall_tick = 0;
   int           stall_mode = 0;
   int           cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic reset_frame_tracker();
      hunt_window = '0;
      hunt_fill   = '0;
      frame_phase = mlcd_pkg::PH_HUNT;
      len_high    = '0;
      frame_len   = '0;
      byte_count  = '0;
      frame_sum   = '0;
   endtask

   task automatic track_frame_byte(input logic [7:0] b);
      logic [15:0] hdr_len;
      case (frame_phase)
         mlcd_pkg::PH_HUNT: begin
            hunt_window = {hunt_window[23:0], b};
            if (hunt_fill < 3'd4) hunt_fill++;
            if (hunt_fill == 3'd4 && hunt_window == HDR_MAGIC)
               frame_phase = mlcd_pkg::PH_LEN_HI;
         end
         mlcd_pkg::PH_LEN_HI: begin
            len_high = b;
            frame_phase = mlcd_pkg::PH_LEN_LO;
         end
         mlcd_pkg::PH_LEN_LO: begin
            hdr_len = {len_high, b};
            if (hdr_len < FRAME_MIN_LEN || hdr_len > FRAME_MAX_LEN) begin
               // drop consumes only the first magic byte
               hunt_window = {HDR_MAGIC[15:0], len_high, b};
               hunt_fill   = 3'd4;
               frame_phase = mlcd_pkg::PH_HUNT;
               pending_pkt_words.push_back('{pkt_byte: 8'h00, byte_offset: DROP_AT,
                  pkt_len: hdr_len, end_of_packet: 1'b1, status: mlcd_pkg::ST_BAD_LEN});
            end else begin
               frame_len   = hdr_len;
               byte_count  = 10'd6;
               frame_sum   = HDR_MAGIC_SUM + len_high + b;
               frame_phase = mlcd_pkg::PH_BODY;
            end
         end
         default: begin
            if (int'(byte_count) + 1 >= int'(frame_len)) begin
               pending_pkt_words.push_back('{pkt_byte: b, byte_offset: byte_count[8:0],
                  pkt_len: frame_len, end_of_packet: 1'b1,
                  status: (b == frame_sum) ? mlcd_pkg::ST_GOOD_END
                                           : mlcd_pkg::ST_BAD_SUM});
               hunt_window = '0;
               hunt_fill   = '0;
               frame_phase = mlcd_pkg::PH_HUNT;
            end else begin
               pending_pkt_words.push_back('{pkt_byte: b, byte_offset: byte_count[8:0],
                  pkt_len: frame_len, end_of_packet: 1'b0,
                  status: mlcd_pkg::ST_IN_PROGRESS});
               frame_sum  = frame_sum + b;
               byte_count = byte_count + 10'd1;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at word %0d: %s got 0x%0h want 0x%0h", words_seen, what, got,
                  want);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= '{rx_byte: b};
      do @(posedge clock); while (!req_ch.ready);
      track_frame_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_pkt_words.size() != 0);
   endtask

   // header, then body_bytes random bytes, then the checksum byte if closed
   task automatic send_frame(input logic [15:0] hdr_len, input int body_bytes,
                             input bit closed, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      logic [47:0] hdr;
      sum = '0;
      hdr = {HDR_MAGIC, hdr_len};
      for (int i = 0; i < 6; i++) begin
         b = hdr[47 - 8 * i -: 8];
         send_byte(b);
         sum = sum + b;
      end
      for (int i = 0; i < body_bytes; i++) begin
         b = 8'($urandom);
         send_byte(b);
         sum = sum + b;
      end
      if (closed) send_byte(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
   endtask

   task automatic test_directed_frames();
      logic [7:0] seq[$];
      // shortest frame with extreme body bytes
      seq = {8'h54, 8'h4A, 8'h53, 8'h47, 8'h00, 8'h09, 8'h00, 8'hFF};
      foreach (seq[i]) send_byte(seq[i]);
      send_byte(HDR_MAGIC_SUM + 8'h09 + 8'hFF);
      // length under minimum
      seq = {8'h54, 8'h4A, 8'h53, 8'h47, 8'h00, 8'h08};
      foreach (seq[i]) send_byte(seq[i]);
      // length over maximum whose length bytes start the next magic
      seq = {8'h54, 8'h4A, 8'h53, 8'h47, 8'h54, 8'h4A, 8'h53, 8'h47, 8'h00, 8'h09,
             8'h5A, 8'hA5};
      foreach (seq[i]) send_byte(seq[i]);
      send_byte(HDR_MAGIC_SUM + 8'h09 + 8'h5A + 8'hA5 + 8'h01);
   endtask

   task automatic test_longest_frame();
      send_frame(16'(FRAME_MAX_LEN), FRAME_MAX_LEN - 7, 1'b1, 1'b1);
      send_frame(16'(FRAME_MAX_LEN - 1), FRAME_MAX_LEN - 8, 1'b1, 1'b0);
   endtask

   task automatic test_pause_until_drained();
      wait_drained();
      send_frame(16'(FRAME_MIN_LEN), FRAME_MIN_LEN - 7, 1'b1, 1'b1);
   endtask

   task automatic test_random_traffic(input int byte_goal);
      int pick;
      int len;
      int n;
      logic [7:0] b;
      while (bytes_sent < byte_goal) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(41, FRAME_MAX_LEN)
                                            : $urandom_range(FRAME_MIN_LEN, 40);
         if (pick < 68) begin
            send_frame(16'(len), len - 7, 1'b1, 1'b1);
         end else if (pick < 80) begin
            send_frame(16'(len), len - 7, 1'b1, 1'b0);
         end else if (pick < 89) begin
            case ($urandom_range(0, 6))
               0: len = 0;
               1: len = FRAME_MIN_LEN - 1;
               2: len = FRAME_MAX_LEN + 1;
               3: len = 65535;
               4: len = 16'h544A;
               5: len = $urandom_range(0, FRAME_MIN_LEN - 1);
               default: len = $urandom_range(FRAME_MAX_LEN + 1, 65535);
            endcase
            send_frame(16'(len), 0, 1'b0, 1'b0);
         end else if (pick < 95) begin
            // noise, biased toward magic bytes for near misses
            n = $urandom_range(1, 8);
            repeat (n) begin
               b = ($urandom_range(0, 3) == 0) ? HDR_MAGIC[8 * $urandom_range(0, 3) +: 8]
                                               : 8'($urandom);
               send_byte(b);
            end
         end else begin
            // cut short: following bytes land in this body
            send_frame(16'(len), $urandom_range(0, len - 8), 1'b0, 1'b0);
         end
      end
   endtask

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[5:0] == 6'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         2: rsp_ch.ready <= (stall_tick[1:0] == 2'd0);
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin : check_words
      mlcd_pkg::rsp_word_type got_w;
      mlcd_pkg::rsp_word_type want_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_w = rsp_ch.data;
         words_seen++;
         if (pending_pkt_words.size() == 0) begin
            report_mismatch("unexpected word", int'(got_w.pkt_byte), 0);
         end else begin
            want_w = pending_pkt_words.pop_front();
            if (got_w.pkt_byte !== want_w.pkt_byte)
               report_mismatch("pkt_byte", int'(got_w.pkt_byte), int'(want_w.pkt_byte));
            if (got_w.byte_offset !== want_w.byte_offset)
               report_mismatch("byte_offset", int'(got_w.byte_offset),
                               int'(want_w.byte_offset));
            if (got_w.pkt_len !== want_w.pkt_len)
               report_mismatch("pkt_len", int'(got_w.pkt_len), int'(want_w.pkt_len));
            if (got_w.end_of_packet !== want_w.end_of_packet)
               report_mismatch("end_of_packet", int'(got_w.end_of_packet),
                               int'(want_w.end_of_packet));
            if (got_w.status !== want_w.status)
               report_mismatch("status", int'(got_w.status), int'(want_w.status));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** magic_length_checksum_deframer_core: FAILED **");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      reset_frame_tracker();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_longest_frame();
      test_random_traffic(ITEM_GOAL * 3 / 4);
      test_pause_until_drained();
      test_random_traffic(ITEM_GOAL);
      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_pkt_words.size() != 0)
         report_mismatch("words never delivered", 0, pending_pkt_words.size());
      if (mismatch_count == 0)
         $display("** magic_length_checksum_deframer_core: PASSED **");
      else
         $display("** magic_length_checksum_deframer_core: FAILED **");
      $finish;
   end

endmodule
